// ===== hdl/spg_pkg.sv =====
// shared types, constants and table builders for the signed power gain
`timescale 1ns / 1ps
`default_nettype none

package spg_pkg;

    localparam int LOG_Q     = 24;
    localparam int EXP_Q     = 30;
    localparam int MAX_ROOTS = 13;

    typedef struct packed {
        logic valid;
        logic neg;
        logic zero;
        logic last;
    } t_side;

    function automatic longint unsigned isqrt64(input longint unsigned v);
        longint unsigned res;
        longint unsigned bv;
        longint unsigned x;
        res = 0;
        bv  = 64'h4000_0000_0000_0000;
        x   = v;
        while (bv > x) bv = bv >> 2;
        while (bv != 0) begin
            if (x >= res + bv) begin
                x   = x - (res + bv);
                res = (res >> 1) + bv;
            end else begin
                res = res >> 1;
            end
            bv = bv >> 2;
        end
        return res;
    endfunction

    function automatic logic [24:0] log_entry(input int i, input int l);
        longint unsigned m;
        longint unsigned acc;
        acc = 0;
        if (i == (1 << l)) begin
            acc = 64'd1 << LOG_Q;
        end else begin
            m = (64'd1 << EXP_Q) + (longint'(i) << (EXP_Q - l));
            for (int k = 0; k < LOG_Q; k++) begin
                m   = (m * m) >> EXP_Q;
                acc = acc << 1;
                if (m >= (64'd1 << (EXP_Q + 1))) begin
                    acc = acc | 64'd1;
                    m   = m >> 1;
                end
            end
        end
        return acc[24:0];
    endfunction

    function automatic logic [31:0] exp_entry(input int i, input int e);
        longint unsigned roots [MAX_ROOTS];
        longint unsigned acc;
        for (int k = 0; k < MAX_ROOTS; k++) roots[k] = 0;
        roots[0] = 64'd1 << (EXP_Q + 1);
        for (int k = 1; k <= e; k++) roots[k] = isqrt64(roots[k - 1] << EXP_Q);
        acc = 64'd1 << EXP_Q;
        if (i == (1 << e)) begin
            acc = 64'd1 << (EXP_Q + 1);
        end else begin
            for (int k = 0; k < e; k++) begin
                if (((i >> k) & 1) != 0) acc = (acc * roots[e - k]) >> EXP_Q;
            end
        end
        return acc[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/spg_log.sv =====
// log2 of the sample magnitude: normalize, table lookup, interpolate
`timescale 1ns / 1ps
`default_nettype none

module spg_log #(
    parameter int LOG_TABLE_ADDR_BITS = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_ce,
    input  wire spg_pkg::t_side      i_side,
    input  wire logic [31:0]         i_mag,
    output spg_pkg::t_side           o_side,
    output logic signed [29:0]       o_lg
);

    localparam int L  = LOG_TABLE_ADDR_BITS;
    localparam int LR = 31 - L;
    localparam int LN = 1 << L;

    logic [24:0] w_lt [LN + 1];

    for (genvar gi = 0; gi <= LN; gi++) begin : g_lt
        localparam logic [24:0] C_ENT = spg_pkg::log_entry(gi, L);
        assign w_lt[gi] = C_ENT;
    end

    // stage 1: leading one and normalize
    logic [4:0]  w_p;
    logic [31:0] w_norm;

    always_comb begin
        w_p = '0;
        for (int b = 0; b < 32; b++) begin
            if (i_mag[b]) w_p = 5'(b);
        end
        w_norm = i_mag << (5'd31 - w_p);
    end

    spg_pkg::t_side r1_side;
    logic [4:0]     r1_p;
    logic [L-1:0]   r1_idx;
    logic [LR-1:0]  r1_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_side <= '0;
        end else if (i_ce) begin
            r1_side <= i_side;
        end
        if (i_ce) begin
            r1_p   <= w_p;
            r1_idx <= w_norm[30 -: L];
            r1_rem <= w_norm[LR-1:0];
        end
    end

    // stage 2: lookup and slope product
    logic [24:0]    w_lo;
    logic [24:0]    w_hi;
    logic [24:0]    w_diff;
    logic [L:0]     w_idx1;

    assign w_idx1 = {1'b0, r1_idx} + (L+1)'(1);
    assign w_lo   = w_lt[r1_idx];
    assign w_hi   = w_lt[w_idx1];
    assign w_diff = w_hi - w_lo;

    spg_pkg::t_side  r2_side;
    logic [4:0]      r2_p;
    logic [24:0]     r2_lo;
    logic [25+LR-1:0] r2_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_side <= '0;
        end else if (i_ce) begin
            r2_side <= r1_side;
        end
        if (i_ce) begin
            r2_p    <= r1_p;
            r2_lo   <= w_lo;
            r2_prod <= (25+LR)'(w_diff) * (25+LR)'(r1_rem);
        end
    end

    // stage 3: integer part plus interpolated fraction
    logic [24:0]       w_lf;
    logic signed [5:0] w_pm16;
    logic signed [29:0] w_lg;

    assign w_lf   = r2_lo + 25'(r2_prod >> LR);
    assign w_pm16 = $signed({1'b0, r2_p}) - 6'sd16;
    assign w_lg   = $signed({w_pm16, 24'b0}) + $signed({5'b0, w_lf});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_side <= '0;
        end else if (i_ce) begin
            o_side <= r2_side;
        end
        if (i_ce) begin
            o_lg <= w_lg;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/signed_power_gain.sv =====
// top level: sign-preserving power-law gain, sign(x)*|x|^g on q16.16 samples
//
//  channel  | handshake                 | beat contents
//  ---------+---------------------------+-----------------------------------------
//  input    | i_valid / o_stall         | i_sample_in, i_trace_last
//  output   | o_valid / i_stall         | o_sample_out, o_saturated, o_trace_last_out
//  config   | psel penable pwrite pready| paddr, pwdata, prdata (gain_exponent)
//
//  one beat per cycle while the output beat is not stalled, nine register stages
//  stages: magnitude, normalize, log lookup, log sum, gain multiply, split,
//  exp lookup, mantissa, shift and clamp into the output register
//  the whole pipeline holds while the output beat is stalled
//  synchronous active-low reset clears valid bits; gain resets to 1.0
`timescale 1ns / 1ps
`default_nettype none

module signed_power_gain #(
    parameter int LOG_TABLE_ADDR_BITS = 8,
    parameter int EXP_TABLE_ADDR_BITS = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_sample_in,
    input  wire logic               i_trace_last,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_sample_out,
    output logic                    o_saturated,
    output logic                    o_trace_last_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int E  = EXP_TABLE_ADDR_BITS;
    localparam int ER = 36 - E;
    localparam int EN = 1 << E;

    // config register
    logic [15:0] r_gain;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {16'd0, r_gain};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= 16'd4096;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_gain <= pwdata[15:0];
        end
    end

    logic w_ce;
    assign w_ce    = !(o_valid && i_stall);
    assign o_stall = !w_ce;

    // stage 0: magnitude and sign
    spg_pkg::t_side r0_side;
    logic [31:0]    r0_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_side <= '0;
        end else if (w_ce) begin
            r0_side.valid <= i_valid;
            r0_side.neg   <= i_sample_in[31];
            r0_side.zero  <= (i_sample_in == 32'sd0);
            r0_side.last  <= i_trace_last;
        end
        if (w_ce) begin
            r0_mag <= i_sample_in[31] ? 32'(-i_sample_in) : i_sample_in;
        end
    end

    spg_pkg::t_side     w3_side;
    logic signed [29:0] w3_lg;

    spg_log #(
        .LOG_TABLE_ADDR_BITS(LOG_TABLE_ADDR_BITS)
    ) u_log (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ce   (w_ce),
        .i_side (r0_side),
        .i_mag  (r0_mag),
        .o_side (w3_side),
        .o_lg   (w3_lg)
    );

    // stage 4: scale by the exponent
    spg_pkg::t_side     r4_side;
    logic signed [46:0] r4_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_side <= '0;
        end else if (w_ce) begin
            r4_side <= w3_side;
        end
        if (w_ce) begin
            r4_z <= 47'(w3_lg) * $signed({31'd0, r_gain});
        end
    end

    // stage 5: integer and fraction split
    logic [46:0]        w_zz;
    spg_pkg::t_side     r5_side;
    logic signed [10:0] r5_n;
    logic [E-1:0]       r5_idx;
    logic [ER-1:0]      r5_rem;

    assign w_zz = r4_z + (47'sd1 <<< 40) + (47'sd1 <<< 45);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_side <= '0;
        end else if (w_ce) begin
            r5_side <= r4_side;
        end
        if (w_ce) begin
            r5_n   <= $signed({1'b0, w_zz[45:36]}) - 11'sd512;
            r5_idx <= w_zz[35 -: E];
            r5_rem <= w_zz[ER-1:0];
        end
    end

    // stage 6: exp lookup and slope product
    logic [31:0] w_et [EN + 1];

    for (genvar gj = 0; gj <= EN; gj++) begin : g_et
        localparam logic [31:0] C_ENT = spg_pkg::exp_entry(gj, E);
        assign w_et[gj] = C_ENT;
    end

    logic [E:0]  w_eidx1;
    logic [31:0] w_elo;
    logic [31:0] w_ediff;

    assign w_eidx1 = {1'b0, r5_idx} + (E+1)'(1);
    assign w_elo   = w_et[r5_idx];
    assign w_ediff = w_et[w_eidx1] - w_elo;

    spg_pkg::t_side     r6_side;
    logic signed [10:0] r6_n;
    logic [31:0]        r6_lo;
    logic [32+ER-1:0]   r6_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_side <= '0;
        end else if (w_ce) begin
            r6_side <= r5_side;
        end
        if (w_ce) begin
            r6_n    <= r5_n;
            r6_lo   <= w_elo;
            r6_prod <= (32+ER)'(w_ediff) * (32+ER)'(r5_rem);
        end
    end

    // stage 7: mantissa
    spg_pkg::t_side     r7_side;
    logic signed [10:0] r7_n;
    logic [31:0]        r7_mant;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_side <= '0;
        end else if (w_ce) begin
            r7_side <= r6_side;
        end
        if (w_ce) begin
            r7_n    <= r6_n;
            r7_mant <= r6_lo + 32'(r6_prod >> ER);
        end
    end

    // stage 8: shift, round, clamp, sign
    logic signed [10:0] w_s;
    logic [63:0]        w_sum;
    logic [32:0]        w_res;
    logic [32:0]        w_limit;
    logic               w_sat;
    logic [32:0]        w_clamp;
    logic [31:0]        w_out;

    always_comb begin
        w_s   = 11'sd30 - r7_n;
        w_sum = '0;
        if (r7_side.zero) begin
            w_res = (r_gain == 16'd0) ? 33'd65536 : 33'd0;
        end else if (r7_n >= 11'sd32) begin
            w_res = 33'h1_0000_0000;
        end else if (r7_n == 11'sd31) begin
            w_res = {r7_mant, 1'b0};
        end else if (r7_n == 11'sd30) begin
            w_res = {1'b0, r7_mant};
        end else if (w_s > 11'sd32) begin
            w_res = '0;
        end else begin
            w_sum = {32'd0, r7_mant} + (64'd1 << (w_s[5:0] - 6'd1));
            w_res = 33'(w_sum >> w_s[5:0]);
        end
        w_limit = r7_side.neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
        w_sat   = (w_res > w_limit);
        w_clamp = w_sat ? w_limit : w_res;
        w_out   = r7_side.neg ? 32'(-w_clamp) : w_clamp[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_ce) begin
            o_valid <= r7_side.valid;
        end
        if (w_ce) begin
            o_sample_out     <= w_out;
            o_saturated      <= w_sat;
            o_trace_last_out <= r7_side.last;
        end
    end

`ifndef SYNTHESIS
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |->
            (o_sample_out == 32'sh7FFF_FFFF || o_sample_out == 32'sh8000_0000))
        else $error("saturated beat not at a range limit");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r7_mant) && $stable(r4_z))
        else $error("pipeline moved during stall");

    a_zero_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r7_side.valid && r7_side.zero |-> !w_sat)
        else $error("zero sample flagged as saturated");
`endif

endmodule

`default_nettype wire

// ===== dv/signed_power_gain_tb.sv =====
// testbench for signed_power_gain: random and directed samples against a power-law predictor
`timescale 1ns / 1ps

module signed_power_gain_tb;

    localparam int LB = 8;
    localparam int EB = 8;
    localparam int N_RANDOM = 630;
    localparam int WATCHDOG_LIMIT = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_sample_in;
    logic               i_trace_last;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_sample_out;
    logic               o_saturated;
    logic               o_trace_last_out;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    signed_power_gain #(
        .LOG_TABLE_ADDR_BITS(LB),
        .EXP_TABLE_ADDR_BITS(EB)
    ) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_sample_in(i_sample_in), .i_trace_last(i_trace_last),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_sample_out(o_sample_out), .o_saturated(o_saturated),
        .o_trace_last_out(o_trace_last_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    typedef struct packed {
        logic [31:0] sample;
        logic        sat;
        logic        last;
    } t_gained;

    class gain_scoreboard;
        t_gained         pending[$];
        logic [15:0]     gain;
        longint unsigned log_lut[(1 << LB) + 1];
        longint unsigned exp_lut[(1 << EB) + 1];
        int              mismatches;
        int              n_checked;
        int              n_sat;

        function new();
            longint unsigned roots[EB + 1];
            longint unsigned m;
            longint unsigned acc;
            gain = 16'd4096;
            mismatches = 0;
            n_checked = 0;
            n_sat = 0;
            for (int i = 0; i < (1 << LB); i++) begin
                m = (64'd1 << 30) + (longint'(i) << (30 - LB));
                acc = 0;
                for (int k = 0; k < 24; k++) begin
                    m = (m * m) >> 30;
                    acc = acc << 1;
                    if (m >= (64'd1 << 31)) begin
                        acc = acc | 1;
                        m = m >> 1;
                    end
                end
                log_lut[i] = acc;
            end
            log_lut[1 << LB] = 64'd1 << 24;
            roots[0] = 64'd1 << 31;
            for (int k = 1; k <= EB; k++) roots[k] = int_sqrt(roots[k - 1] << 30);
            for (int i = 0; i < (1 << EB); i++) begin
                acc = 64'd1 << 30;
                for (int k = 0; k < EB; k++)
                    if (((i >> k) & 1) != 0) acc = (acc * roots[EB - k]) >> 30;
                exp_lut[i] = acc;
            end
            exp_lut[1 << EB] = 64'd1 << 31;
        endfunction

        static function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function t_gained power_gain(logic [31:0] raw, logic last);
            t_gained         g;
            logic            neg;
            longint unsigned mag, lim, res, frac, r, idx, lf, zz, f, mant;
            longint          lg, z;
            int              p, n, s;
            neg = raw[31];
            mag = neg ? longint'(32'(-raw)) : longint'(raw);
            if (neg && raw == 32'h8000_0000) mag = 64'h8000_0000;
            lim = neg ? (64'd1 << 31) : ((64'd1 << 31) - 1);
            g.sat = 1'b0;
            if (mag == 0) begin
                res = (gain == 0) ? 64'd65536 : 64'd0;
            end else begin
                p = 31;
                while (((mag >> p) & 1) == 0) p--;
                frac = (mag << (31 - p)) & 64'h7FFF_FFFF;
                idx = frac >> (31 - LB);
                r = frac & ((64'd1 << (31 - LB)) - 1);
                lf = log_lut[idx] + (((log_lut[idx + 1] - log_lut[idx]) * r) >> (31 - LB));
                lg = longint'(p - 16) * (64'sd1 << 24) + longint'(lf);
                z = lg * longint'({48'd0, gain}) + 64'sd16 * (64'sd1 << 36);
                zz = longint'(z + (64'sd1 << 45));
                n = int'(zz >> 36) - 512;
                f = zz & ((64'd1 << 36) - 1);
                idx = f >> (36 - EB);
                r = f & ((64'd1 << (36 - EB)) - 1);
                mant = exp_lut[idx] + (((exp_lut[idx + 1] - exp_lut[idx]) * r) >> (36 - EB));
                if (n >= 32) begin
                    res = lim + 1;
                end else if (n >= 30) begin
                    res = mant << (n - 30);
                end else begin
                    s = 30 - n;
                    res = (s > 62) ? 64'd0 : ((mant + (64'd1 << (s - 1))) >> s);
                end
            end
            if (res > lim) begin
                res = lim;
                g.sat = 1'b1;
            end
            if (neg) res = ~res + 1;
            g.sample = res[31:0];
            g.last = last;
            return g;
        endfunction

        function void note_sample(logic [31:0] raw, logic last);
            t_gained g;
            g = power_gain(raw, last);
            if (g.sat) n_sat++;
            pending.push_back(g);
        endfunction

        function void check_result(logic [31:0] sample, logic sat, logic last);
            t_gained want;
            n_checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: sample %h sat %b last %b", sample, sat, last);
                return;
            end
            want = pending.pop_front();
            if (want.sample !== sample || want.sat !== sat || want.last !== last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %h/%b/%b got %h/%b/%b (gain %h)",
                             want.sample, want.sat, want.last, sample, sat, last, gain);
            end
        endfunction
    endclass

    gain_scoreboard sb;
    int             idle_cycles;
    int             n_sent;
    bit             timed_out;

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // output side: random stall per beat
    initial begin
        int hold;
        i_stall = 1'b1;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                sb.check_result(o_sample_out, o_saturated, o_trace_last_out);
                hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
                if (hold > 0) i_stall <= 1'b1;
            end else if (i_stall) begin
                if (hold > 0) hold--;
                if (hold == 0) i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_gain(logic [15:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.gain = value;
    endtask

    // i_valid stays high after the beat so a following beat can go back to back
    task automatic send_sample(logic [31:0] raw, logic last, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample_in <= raw;
        i_trace_last <= last;
        do @(posedge i_clk); while (o_stall);
        sb.note_sample(raw, last);
        n_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] random_sample();
        logic [31:0] v;
        int sh;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: begin
                sh = $urandom_range(0, 31);
                v = $urandom >> sh;
                if ($urandom_range(0, 1)) v = -v;
            end
            2: v = 32'(int'($urandom_range(0, 8)) - 4);
            3: v = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            4: v = $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
            default: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 9)
                                              : 32'h8000_0000 + $urandom_range(0, 9);
        endcase
        return v;
    endfunction

    initial begin
        logic [15:0] gains[7];
        logic [31:0] corners[12];
        sb = new();
        idle_cycles = 0;
        n_sent = 0;
        timed_out = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_sample_in = '0;
        i_trace_last = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        corners = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h0000_8000,
                    32'h5555_5555, 32'hAAAA_AAAA, 32'h0180_0000};
        // reset gain of 1.0 first, then the exponent extremes
        foreach (corners[k]) send_sample(corners[k], k[0], 1'b0);
        drain();
        write_gain(16'h0000);
        foreach (corners[k]) if (k < 5) send_sample(corners[k], 1'b1, 1'b0);
        drain();
        write_gain(16'hFFFF);
        foreach (corners[k]) if (k < 7) send_sample(corners[k], 1'b0, 1'b1);
        drain();

        gains = '{16'h1000, 16'h2000, 16'h0800, 16'h0001, 16'hFFFF, 16'h0000, 16'h1800};
        for (int ph = 0; ph < 9; ph++) begin
            write_gain(ph < 7 ? gains[ph] : 16'($urandom));
            for (int k = 0; k < N_RANDOM / 9; k++)
                send_sample(random_sample(), $urandom_range(0, 7) == 0,
                            (ph % 3) != 1);
            drain();
        end

        $display("sent %0d samples over 12 gain settings, %0d checked, %0d clamped",
                 n_sent, sb.n_checked, sb.n_sat);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== signed_power_gain.f =====
hdl/spg_pkg.sv
hdl/spg_log.sv
hdl/signed_power_gain.sv
dv/signed_power_gain_tb.sv
